>>> rtl/wcb_pkg.sv
package wcb_pkg;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 7;
  localparam int AGE_W   = 16;
  localparam int ACT_W   = 2;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY = 1'd1;

  localparam logic [LEN_W-1:0] CAP_RESET   = 7'd64;
  localparam logic [AGE_W-1:0] DELAY_RESET = 16'd1000;
  localparam logic [AGE_W-1:0] AGE_TOP     = 16'hFFFF;

  // action codes
  localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TICK    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_DISCARD = 2'd3;

  // run descriptor queue between front and back
  localparam int DQ_DEPTH = 4;

  typedef struct packed {
    logic [LEN_W-1:0] len;
  } desc_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [LEN_W-1:0]  len;
  } out_item_t;

endpackage

>>> rtl/wcb_if.sv
interface wcb_in_if;
  import wcb_pkg::*;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

interface wcb_out_if;
  import wcb_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_byte;
  logic [LEN_W-1:0]  run_length;

  modport source (output valid, out_byte, last_byte, run_length, input ready);
  modport sink   (input valid, out_byte, last_byte, run_length, output ready);
endinterface

>>> rtl/wcb_ram.sv
module wcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/wcb_desc_queue.sv
module wcb_desc_queue import wcb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output desc_t head
);

  localparam int PW = $clog2(DQ_DEPTH);
  localparam int CW = $clog2(DQ_DEPTH + 1);

  desc_t         slots [DQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DQ_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("descriptor pushed into full queue");
  assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("descriptor popped from empty queue");
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DQ_DEPTH))
    else $error("descriptor count overflow");

endmodule

>>> rtl/wcb_front.sv
module wcb_front import wcb_pkg::*; #(
  parameter int STORE_DEPTH = 64,
  parameter int RING_DEPTH  = 128,
  parameter int PTR_W       = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  wcb_in_if.sink                 in_ch,
  input  logic [LEN_W-1:0]       capacity_in_use,
  input  logic [AGE_W-1:0]       max_delay_ticks,
  input  logic [PTR_W-1:0]       rd_ptr,
  input  logic                   q_full,
  output logic                   push,
  output desc_t                  push_desc,
  output logic                   ram_we,
  output logic [PTR_W-2:0]       ram_waddr,
  output logic [BYTE_W-1:0]      ram_wdata
);

  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(STORE_DEPTH);

  logic [PTR_W-1:0] base;
  logic [PTR_W-1:0] base_next;
  logic [LEN_W-1:0] fill;
  logic [LEN_W-1:0] fill_next;
  logic [AGE_W-1:0] age;
  logic [AGE_W-1:0] age_next;

  logic [LEN_W-1:0] cap_eff;
  logic [LEN_W-1:0] fill_inc;
  logic [AGE_W-1:0] age_wr;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] occupancy;
  logic             ring_space;
  logic             over_cap;
  logic             pre_flush;
  logic             accept;

  // effective capacity, clamped to 1..STORE_DEPTH
  always_comb begin
    if (capacity_in_use == '0) begin
      cap_eff = LEN_W'(1);
    end else if (capacity_in_use > DEPTH_L) begin
      cap_eff = DEPTH_L;
    end else begin
      cap_eff = capacity_in_use;
    end
  end

  assign wr_ptr     = base + PTR_W'(fill);
  assign occupancy  = wr_ptr - rd_ptr;
  assign ring_space = (occupancy < PTR_W'(RING_DEPTH));
  assign over_cap   = (fill >= cap_eff);
  assign fill_inc   = fill + 1'b1;
  assign age_wr     = (fill == '0) ? '0 : age;

  // acceptance per action
  always_comb begin
    unique case (in_ch.action)
      ACT_WRITE:   in_ch.ready = !q_full && ring_space && !over_cap;
      ACT_FLUSH:   in_ch.ready = !q_full;
      default:     in_ch.ready = 1'b1;
    endcase
  end

  assign accept    = in_ch.valid && in_ch.ready;
  // a write that finds the store at or past capacity first sends the held run
  assign pre_flush = in_ch.valid && (in_ch.action == ACT_WRITE) && over_cap && !q_full;

  assign ram_we    = accept && (in_ch.action == ACT_WRITE);
  assign ram_waddr = wr_ptr[PTR_W-2:0];
  assign ram_wdata = in_ch.data_byte;

  // classify the item and update the open run
  always_comb begin
    base_next     = base;
    fill_next     = fill;
    age_next      = age;
    push          = 1'b0;
    push_desc.len = fill;
    if (pre_flush) begin
      push      = 1'b1;
      base_next = base + PTR_W'(fill);
      fill_next = '0;
      age_next  = '0;
    end else if (accept) begin
      unique case (in_ch.action)
        ACT_WRITE: begin
          if (fill_inc >= cap_eff || age_wr >= max_delay_ticks) begin
            push          = 1'b1;
            push_desc.len = fill_inc;
            base_next     = base + PTR_W'(fill_inc);
            fill_next     = '0;
            age_next      = '0;
          end else begin
            fill_next = fill_inc;
            age_next  = age_wr;
          end
        end
        ACT_TICK: begin
          if (fill != '0 && age != AGE_TOP) begin
            age_next = age + 1'b1;
          end
        end
        ACT_FLUSH: begin
          if (fill != '0) begin
            push      = 1'b1;
            base_next = base + PTR_W'(fill);
            fill_next = '0;
            age_next  = '0;
          end
        end
        default: begin
          fill_next = '0;
          age_next  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
      fill <= '0;
      age  <= '0;
    end else begin
      base <= base_next;
      fill <= fill_next;
      age  <= age_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= DEPTH_L)
    else $error("open run larger than the store");
  assert property (@(posedge clk) disable iff (rst) occupancy <= PTR_W'(RING_DEPTH))
    else $error("byte ring overrun");
  assert property (@(posedge clk) disable iff (rst) push |=> fill == '0)
    else $error("open run not cleared after a flush");

endmodule

>>> rtl/wcb_back.sv
module wcb_back import wcb_pkg::*; #(
  parameter int PTR_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  desc_t             head,
  output logic              pop,
  output logic [PTR_W-1:0]  rd_ptr,
  output logic              ram_re,
  output logic [PTR_W-2:0]  ram_raddr,
  input  logic [BYTE_W-1:0] ram_rdata,
  wcb_out_if.source         out_ch
);

  logic [LEN_W-1:0] idx;
  logic             inflight;
  logic             inflight_last;
  logic [LEN_W-1:0] inflight_len;
  out_item_t        slot0;
  out_item_t        slot1;
  out_item_t        new_item;
  logic [1:0]       ocnt;
  logic             issue;
  logic             is_last;
  logic             out_pop;

  assign out_pop = (ocnt != 2'd0) && out_ch.ready;
  // a read is issued only when its byte is sure of a slot in the output pair
  assign issue   = !q_empty && ((ocnt + 2'(inflight)) < (2'd2 + 2'(out_pop)));
  assign is_last = ((idx + 1'b1) == head.len);
  assign pop     = issue && is_last;

  assign ram_re    = issue;
  assign ram_raddr = rd_ptr[PTR_W-2:0];

  // read issue across the runs
  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      rd_ptr   <= '0;
      inflight <= 1'b0;
    end else begin
      inflight <= issue;
      if (issue) begin
        rd_ptr <= rd_ptr + 1'b1;
        idx    <= is_last ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      inflight_last <= is_last;
      inflight_len  <= head.len;
    end
  end

  assign new_item = '{data: ram_rdata, last: inflight_last, len: inflight_len};

  // two-entry output pair, head in slot0
  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= '0;
    end else begin
      ocnt <= ocnt + 2'(inflight) - 2'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (out_pop) begin
      slot0 <= (inflight && ocnt == 2'd1) ? new_item : slot1;
      if (inflight && ocnt == 2'd2) begin
        slot1 <= new_item;
      end
    end else if (inflight) begin
      if (ocnt == 2'd0) begin
        slot0 <= new_item;
      end else begin
        slot1 <= new_item;
      end
    end
  end

  assign out_ch.valid      = (ocnt != 2'd0);
  assign out_ch.out_byte   = slot0.data;
  assign out_ch.last_byte  = slot0.last;
  assign out_ch.run_length = slot0.len;

  assert property (@(posedge clk) disable iff (rst) (ocnt + 2'(inflight)) <= 2'd2)
    else $error("output pair overcommitted");
  assert property (@(posedge clk) disable iff (rst) pop |-> issue && (idx + 1'b1) == head.len)
    else $error("run retired before its last byte");
  assert property (@(posedge clk) disable iff (rst)
      (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.out_byte) &&
      $stable(out_ch.last_byte) && $stable(out_ch.run_length)))
    else $error("output item changed while stalled");

endmodule

>>> rtl/write_coalescing_buffer.sv
// Write coalescing buffer with a timeout.
// in_ch carries one action per item: write a byte, tick, flush or discard.
// out_ch returns flushed bytes oldest first, with last_byte on the final
// byte and run_length on every byte of a run.
// Configuration: cfg_we, cfg_index and cfg_data write capacity_in_use (0)
// or max_delay_ticks (1); write only while the block is idle.
// Throughput: one item per cycle on in_ch while in_ch.ready is high. A write
// that meets a store already at capacity waits while the held run is sent first.
// Runs drain at one byte per cycle while out_ch is ready, set by the single
// read port of the byte ring; with the drain idle, the first byte of a run
// passes the run queue, the ring's registered read and the output pair to out_ch.
// A ring of twice the store depth and a four-entry run queue decouple the
// front from the drain: the front takes writes while earlier runs drain,
// and holds in_ch.ready low only for a full ring or run queue or a store at capacity.
// When out_ch stalls, the two-entry output pair fills, reads pause, and
// the ring and run queue back up into in_ch.
// Reset (rst, synchronous) empties the store, queue and output, and sets
// capacity to 64 and the delay limit to 1000 ticks; no clearing pass.
module write_coalescing_buffer import wcb_pkg::*; #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  wcb_in_if.sink                in_ch,
  wcb_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RING_DEPTH = 2 ** $clog2(2 * STORE_DEPTH);
  localparam int PTR_W      = $clog2(RING_DEPTH) + 1;

  logic [LEN_W-1:0]  capacity_in_use;
  logic [AGE_W-1:0]  max_delay_ticks;
  logic [PTR_W-1:0]  rd_ptr;
  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  desc_t             push_desc;
  desc_t             head;
  logic              ram_we;
  logic [PTR_W-2:0]  ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [PTR_W-2:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAP_RESET;
      max_delay_ticks <= DELAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAPACITY:  capacity_in_use <= cfg_data[LEN_W-1:0];
        REG_MAX_DELAY: max_delay_ticks <= cfg_data[AGE_W-1:0];
        default: ;
      endcase
    end
  end

  wcb_front #(
    .STORE_DEPTH (STORE_DEPTH),
    .RING_DEPTH  (RING_DEPTH),
    .PTR_W       (PTR_W)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_ch           (in_ch),
    .capacity_in_use (capacity_in_use),
    .max_delay_ticks (max_delay_ticks),
    .rd_ptr          (rd_ptr),
    .q_full          (q_full),
    .push            (push),
    .push_desc       (push_desc),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata)
  );

  wcb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wcb_desc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  wcb_back #(
    .PTR_W (PTR_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .rd_ptr    (rd_ptr),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_ch    (out_ch)
  );

endmodule

>>> tb/write_coalescing_buffer_tb.sv
`timescale 1ns / 100ps

module write_coalescing_buffer_tb;
  import wcb_pkg::*;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int HOLD_CYCLES = 500;
  localparam int SETTLE_CYCLES = 10;

  // expected byte runs, predicted from the accepted actions
  class coalesce_board;
    logic [BYTE_W-1:0] held [DEPTH];
    logic [LEN_W-1:0]  fill;
    logic [AGE_W-1:0]  age;
    logic [LEN_W-1:0]  capacity;
    logic [AGE_W-1:0]  delay_limit;
    out_item_t         due_bytes [$];
    int unsigned       errors;
    int unsigned       items_taken;
    int unsigned       bytes_checked;
    int unsigned       runs_checked;

    function new();
      fill = '0;
      age = '0;
      capacity = CAP_RESET;
      delay_limit = DELAY_RESET;
      errors = 0;
      items_taken = 0;
      bytes_checked = 0;
      runs_checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_CAPACITY) capacity = val[LEN_W-1:0];
      else if (idx == REG_MAX_DELAY) delay_limit = val[AGE_W-1:0];
    endfunction

    // capacity clamped into 1..DEPTH
    function int unsigned cap_now();
      int unsigned c;
      c = capacity;
      if (c < 1) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
    endfunction

    // queue the whole held run, oldest first
    function void release_run();
      out_item_t b;
      for (int i = 0; i < fill; i++) begin
        b.data = held[i[IDX_W-1:0]];
        b.last = (i + 1 == fill);
        b.len  = fill;
        due_bytes.push_back(b);
      end
      fill = '0;
      age = '0;
    endfunction

    function void absorb(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] dat);
      int unsigned c;
      c = cap_now();
      items_taken++;
      case (act)
        ACT_WRITE: begin
          if (fill >= c) release_run();
          if (fill == 0) age = '0;
          held[fill[IDX_W-1:0]] = dat;
          fill = fill + 1'b1;
          if (fill >= c || age >= delay_limit) release_run();
        end
        ACT_TICK: begin
          if (fill > 0 && age != AGE_TOP) age = age + 1'b1;
        end
        ACT_FLUSH: begin
          release_run();
        end
        default: begin
          fill = '0;
          age = '0;
        end
      endcase
    endfunction

    function void compare(logic [BYTE_W-1:0] data, logic last, logic [LEN_W-1:0] len);
      out_item_t want;
      if (due_bytes.size() == 0) begin
        $error("unexpected byte %02h, no run pending", data);
        errors++;
        return;
      end
      want = due_bytes.pop_front();
      bytes_checked++;
      if (want.last) runs_checked++;
      if (data !== want.data) begin
        $error("out_byte: expected %02h, got %02h", want.data, data);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_byte: expected %0b, got %0b", want.last, last);
        errors++;
      end
      if (len !== want.len) begin
        $error("run_length: expected %0d, got %0d", want.len, len);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return due_bytes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wcb_in_if  in_ch ();
  wcb_out_if out_ch ();

  write_coalescing_buffer #(.STORE_DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  coalesce_board books;
  int unsigned   burst_left = 0;
  bit            steady = 1'b0;
  bit            hold_request = 1'b0;

  always #6 clk = ~clk;

  // output side: every accepted byte goes to the board
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      books.compare(out_ch.out_byte, out_ch.last_byte, out_ch.run_length);
  end

  // receiver: changing stall patterns, plus a long hold on request
  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned phase;
    logic rdy;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    phase = 0;
    forever begin
      if (hold_left == 0 && hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (mode)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 9) >= 3);
          default: rdy = (phase % 4 != 3);
        endcase
      end
      out_ch.ready <= rdy;
      @(posedge clk);
    end
  end

  // offer one item, with a random gap at the start of each burst
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] dat);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.data_byte <= dat;
    do @(posedge clk); while (!in_ch.ready);
    books.absorb(act, dat);
  endtask

  // stop offering and wait until every predicted byte has come out
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (books.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    books.set_reg(idx, val[CFG_DATA_W-1:0]);
  endtask

  task automatic send_random();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) send_item(ACT_WRITE, BYTE_W'($urandom_range(0, 255)));
    else if (r < 85) send_item(ACT_TICK, BYTE_W'($urandom_range(0, 255)));
    else if (r < 93) send_item(ACT_FLUSH, BYTE_W'($urandom_range(0, 255)));
    else send_item(ACT_DISCARD, BYTE_W'($urandom_range(0, 255)));
  endtask

  function automatic int unsigned pick_capacity();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return DEPTH;
    if (r == 2) return $urandom_range(DEPTH + 1, 127);
    return $urandom_range(1, 12);
  endfunction

  function automatic int unsigned pick_delay();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 65535;
    if (r == 2) return 1000;
    return $urandom_range(1, 8);
  endfunction

  initial begin : stimulus
    books = new();
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_TICK;
    in_ch.data_byte <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store: flush, tick and discard do nothing
    send_item(ACT_FLUSH, 8'h00);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_DISCARD, 8'h00);
    // byte extremes, explicit flush
    send_item(ACT_WRITE, 8'h00);
    send_item(ACT_WRITE, 8'hFF);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_FLUSH, 8'h00);
    // discard drops a held byte silently
    send_item(ACT_WRITE, 8'hA5);
    send_item(ACT_DISCARD, 8'h00);
    send_item(ACT_FLUSH, 8'h00);

    // capacity zero behaves as one
    settle();
    write_reg(REG_CAPACITY, 0);
    send_item(ACT_WRITE, 8'h5A);

    // capacity above the store depth, zero delay flushes every write
    settle();
    write_reg(REG_CAPACITY, 127);
    write_reg(REG_MAX_DELAY, 0);
    send_item(ACT_WRITE, 8'h3C);
    send_item(ACT_WRITE, 8'hC3);

    // age reaching the limit on a write
    settle();
    write_reg(REG_CAPACITY, DEPTH);
    write_reg(REG_MAX_DELAY, 2);
    send_item(ACT_WRITE, 8'h01);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_WRITE, 8'h02);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_WRITE, 8'h03);

    // capacity lowered under the fill: held run, then a run of one
    settle();
    write_reg(REG_MAX_DELAY, 1000);
    send_item(ACT_WRITE, 8'h11);
    send_item(ACT_WRITE, 8'h22);
    send_item(ACT_WRITE, 8'h33);
    settle();
    write_reg(REG_CAPACITY, 1);
    send_item(ACT_WRITE, 8'h44);

    // a full store of random bytes
    settle();
    write_reg(REG_CAPACITY, DEPTH);
    repeat (DEPTH) send_item(ACT_WRITE, BYTE_W'($urandom_range(0, 255)));

    // long output hold while writes keep coming: input must back up
    settle();
    write_reg(REG_CAPACITY, 4);
    hold_request = 1'b1;
    steady = 1'b1;
    repeat (40) send_item(ACT_WRITE, BYTE_W'($urandom_range(0, 255)));
    steady = 1'b0;

    // random phases under random settings
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      write_reg(REG_CAPACITY, pick_capacity());
      write_reg(REG_MAX_DELAY, pick_delay());
      repeat ($urandom_range(6, 10)) send_random();
    end

    settle();
    $display("%0d items accepted, %0d bytes checked in %0d runs",
             books.items_taken, books.bytes_checked, books.runs_checked);
    $display("covered capacities 0..127, delay limits from zero up, a long output hold");
    if (books.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
